// ===== sv/dou_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants for the differential odometry block.
// No dependencies; every other file imports this package.
package dou_pkg;

    // field widths
    localparam int TICK_W      = 16;
    localparam int HEAD_IN_W   = 16;
    localparam int SCALE_W     = 24;
    localparam int POS_W       = 32;
    localparam int OHEAD_W     = 27;
    localparam int DIST_W      = 32;
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 128;
    localparam int CFG_IDX_W   = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_SCALE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_SCALE = 2'd1;

    localparam logic [SCALE_W-1:0] LINEAR_SCALE_RESET  = 24'd54330;
    localparam logic [SCALE_W-1:0] ANGULAR_SCALE_RESET = 24'd65451;

    // angles, Q3.24 radians
    localparam int ANG_W = 28;
    localparam logic signed [ANG_W-1:0] PI_Q24      = 28'sd52707179;
    localparam logic signed [ANG_W-1:0] TWO_PI_Q24  = 28'sd105414358;
    localparam logic signed [ANG_W-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam int TWO_PI_W = 27;

    // centidegrees to radians, Q40
    localparam logic [31:0] DEG_TO_RAD_Q40 = 32'd191900981;
    localparam int CONV_W    = 44;
    localparam int CONV_FRAC = 16;

    // shared multiplier
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // CORDIC
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ATAN_ENTRIES     = 24;
    localparam int ATAN_IDX_W       = $clog2(ATAN_ENTRIES);
    localparam int ATAN_W           = 24;
    localparam int XY_W             = 33;
    localparam logic signed [XY_W-1:0] CORDIC_INIT_Q30 = 33'sd652032874;

    // position step: magnitude of tick sum times scale, times |cos| or |sin|, >> 38
    localparam int PMAG_W   = TICK_W + 1 + SCALE_W;
    localparam int MLO_W    = 20;
    localparam int MHI_W    = PMAG_W - MLO_W;
    localparam int ACC_W    = 72;
    localparam int MUL_FRAC = 38;
    localparam int STEP_W   = ACC_W - MUL_FRAC;

    // heading wrap
    localparam int H_W        = PMAG_W + 1;
    localparam int WRAP_M_W   = PMAG_W;
    localparam int WRAP_STEPS = WRAP_M_W - TWO_PI_W + 1;
    localparam int WRAP_CNT_W = $clog2(WRAP_STEPS);

    typedef struct packed {
        logic                    start;
        logic signed [ANG_W-1:0] angle;
    } cordic_req_t;

    typedef struct packed {
        logic                   busy;
        logic signed [XY_W-1:0] cos_val;
        logic signed [XY_W-1:0] sin_val;
    } cordic_res_t;

    typedef struct packed {
        logic                  start;
        logic signed [H_W-1:0] value;
    } wrap_req_t;

    typedef struct packed {
        logic                    busy;
        logic signed [ANG_W-1:0] heading;
    } wrap_res_t;

    function automatic logic [ATAN_W-1:0] atan_q24(input logic [ATAN_IDX_W-1:0] idx);
        logic [ATAN_W-1:0] v;
        case (idx)
            5'd0:    v = 24'd13176795;
            5'd1:    v = 24'd7778716;
            5'd2:    v = 24'd4110060;
            5'd3:    v = 24'd2086331;
            5'd4:    v = 24'd1047214;
            5'd5:    v = 24'd524117;
            5'd6:    v = 24'd262123;
            5'd7:    v = 24'd131069;
            5'd8:    v = 24'd65536;
            5'd9:    v = 24'd32768;
            5'd10:   v = 24'd16384;
            5'd11:   v = 24'd8192;
            5'd12:   v = 24'd4096;
            5'd13:   v = 24'd2048;
            5'd14:   v = 24'd1024;
            5'd15:   v = 24'd512;
            5'd16:   v = 24'd256;
            5'd17:   v = 24'd128;
            5'd18:   v = 24'd64;
            5'd19:   v = 24'd32;
            5'd20:   v = 24'd16;
            5'd21:   v = 24'd8;
            5'd22:   v = 24'd4;
            5'd23:   v = 24'd2;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== sv/differential_odometry_update.sv =====
`timescale 1ns / 1ps
// Differential-drive odometry update: top-level sequencer, state and handshakes.
// Depends on dou_pkg, dou_mul, dou_cordic and dou_hwrap.
//
//  port group  | dir | word contents (lowest bit first)
//  s_*         | in  | left_ticks, right_ticks, heading_centideg
//  m_*         | out | pos_x, pos_y, own_heading, distance_total, zero pad
//  cfg_*       | in  | index 0 linear_scale, index 1 angular_scale
//
// The time from acceptance of a word to its result is set by the 15-step heading
// wrap unit running beside the CORDIC; above 18 CORDIC_STEPS the CORDIC sets it.
// s_tready is high only between words. A finished result waits in the output
// register while the next word is taken.
// Reset clears position, heading and distance and loads the default scales.
module differential_odometry_update #(
    parameter int CORDIC_STEPS = dou_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // left_ticks[15:0], right_ticks[31:16], heading_centideg[47:32]
    input  logic [dou_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // pos_x[31:0], pos_y[63:32], own_heading[90:64], distance_total[122:91]
    output logic [dou_pkg::OUT_TDATA_W-1:0] m_tdata,
    input  logic                            cfg_we,
    input  logic [dou_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [dou_pkg::SCALE_W-1:0]     cfg_data
);
    import dou_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CONV   = 4'd1;
    localparam logic [3:0] ST_ANG    = 4'd2;
    localparam logic [3:0] ST_FOLD   = 4'd3;
    localparam logic [3:0] ST_HSUM   = 4'd4;
    localparam logic [3:0] ST_HSTART = 4'd5;
    localparam logic [3:0] ST_HWAIT  = 4'd6;
    localparam logic [3:0] ST_MXH    = 4'd7;
    localparam logic [3:0] ST_MXL    = 4'd8;
    localparam logic [3:0] ST_MYH    = 4'd9;
    localparam logic [3:0] ST_MYL    = 4'd10;
    localparam logic [3:0] ST_ACCY   = 4'd11;
    localparam logic [3:0] ST_RND    = 4'd12;
    localparam logic [3:0] ST_UPD    = 4'd13;
    localparam logic [3:0] ST_DONE   = 4'd14;

    localparam logic [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (MUL_FRAC - 1);
    localparam int PAD_W = OUT_TDATA_W - 2 * POS_W - OHEAD_W - DIST_W;

    logic [3:0] state_reg, state_next;

    logic [SCALE_W-1:0]      lin_scale_reg, ang_scale_reg;
    logic [POS_W-1:0]        x_reg, y_reg;
    logic signed [ANG_W-1:0] heading_acc_reg;
    logic [DIST_W-1:0]       dist_reg;
    logic                    m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]  m_tdata_reg;

    logic signed [TICK_W-1:0]    lt_reg, rt_reg;
    logic signed [HEAD_IN_W-1:0] cd_reg;
    logic signed [ANG_W-1:0]     ang_reg;
    logic                        fold_reg;
    logic [PMAG_W-1:0]           p_mag_reg;
    logic                        p_neg_reg;
    logic signed [H_W-1:0]       h_reg;
    logic [ACC_W-1:0]            acc_reg;
    logic [STEP_W-1:0]           dxm_reg, dym_reg;

    logic signed [TICK_W:0]   tick_sum, tick_diff;
    logic [TICK_W:0]          sum_mag, diff_mag;
    logic [HEAD_IN_W-1:0]     cd_mag;
    logic [CONV_W-1:0]        conv_rnd;
    logic signed [ANG_W-1:0]  ang_mag, ang_signed, ang_wrapped, ang_folded;
    logic                     fold_now;
    logic signed [H_W-1:0]    h_term, h_sum;
    logic [ACC_W-1:0]         acc_rnd;
    logic                     cx_neg, cy_neg, dx_neg, dy_neg;
    logic [MUL_W-1:0]         cx_mag, cy_mag;
    logic [DIST_W+3:0]        dist_sum;
    logic [MUL_W-1:0]         mul_a, mul_b;
    logic [PROD_W-1:0]        mul_p;

    cordic_req_t creq;
    cordic_res_t cres;
    wrap_req_t   wreq;
    wrap_res_t   wres;

    dou_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    dou_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (creq),
        .res   (cres)
    );

    dou_hwrap u_hwrap (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (wreq),
        .res   (wres)
    );

    // tick sum, difference and magnitudes
    always_comb
    begin
        tick_sum  = {lt_reg[TICK_W-1], lt_reg} + {rt_reg[TICK_W-1], rt_reg};
        tick_diff = {rt_reg[TICK_W-1], rt_reg} - {lt_reg[TICK_W-1], lt_reg};
        sum_mag   = tick_sum[TICK_W] ? (TICK_W+1)'(-tick_sum) : tick_sum;
        diff_mag  = tick_diff[TICK_W] ? (TICK_W+1)'(-tick_diff) : tick_diff;
        cd_mag    = cd_reg[HEAD_IN_W-1] ? HEAD_IN_W'(-cd_reg) : cd_reg;
    end

    // heading conversion, wrap by 2*pi and fold by pi
    always_comb
    begin
        conv_rnd   = mul_p[CONV_W-1:0] + CONV_W'(32768);
        ang_mag    = signed'(conv_rnd[CONV_W-1:CONV_FRAC]);
        ang_signed = cd_reg[HEAD_IN_W-1] ? -ang_mag : ang_mag;
        if (ang_signed > PI_Q24)
            ang_wrapped = ang_signed - TWO_PI_Q24;
        else if (ang_signed < -PI_Q24)
            ang_wrapped = ang_signed + TWO_PI_Q24;
        else
            ang_wrapped = ang_signed;

        fold_now = 1'b0;
        if (ang_reg > HALF_PI_Q24)
        begin
            ang_folded = ang_reg - PI_Q24;
            fold_now   = 1'b1;
        end
        else if (ang_reg < -HALF_PI_Q24)
        begin
            ang_folded = ang_reg + PI_Q24;
            fold_now   = 1'b1;
        end
        else
        begin
            ang_folded = ang_reg;
        end
    end

    // heading increment and step magnitudes
    always_comb
    begin
        h_term = signed'({1'b0, mul_p[PMAG_W-1:0]});
        h_sum  = (tick_diff[TICK_W] ? -h_term : h_term)
               + {{(H_W-ANG_W){heading_acc_reg[ANG_W-1]}}, heading_acc_reg};

        cx_neg = fold_reg ? (cres.cos_val > 0) : (cres.cos_val < 0);
        cy_neg = fold_reg ? (cres.sin_val > 0) : (cres.sin_val < 0);
        cx_mag = cres.cos_val[XY_W-1] ? MUL_W'(-cres.cos_val) : cres.cos_val[MUL_W-1:0];
        cy_mag = cres.sin_val[XY_W-1] ? MUL_W'(-cres.sin_val) : cres.sin_val[MUL_W-1:0];
        dx_neg = p_neg_reg ^ cx_neg;
        dy_neg = p_neg_reg ^ cy_neg;

        acc_rnd  = acc_reg + ROUND_HALF;
        dist_sum = (DIST_W+4)'(dist_reg) + (DIST_W+4)'(dxm_reg) + (DIST_W+4)'(dym_reg);
    end

    // shared multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_CONV:
            begin
                mul_a = MUL_W'(cd_mag);
                mul_b = DEG_TO_RAD_Q40;
            end
            ST_ANG:
            begin
                mul_a = MUL_W'(sum_mag);
                mul_b = MUL_W'(lin_scale_reg);
            end
            ST_FOLD:
            begin
                mul_a = MUL_W'(diff_mag);
                mul_b = MUL_W'(ang_scale_reg);
            end
            ST_MXH:
            begin
                mul_a = MUL_W'(p_mag_reg[PMAG_W-1:MLO_W]);
                mul_b = cx_mag;
            end
            ST_MXL:
            begin
                mul_a = MUL_W'(p_mag_reg[MLO_W-1:0]);
                mul_b = cx_mag;
            end
            ST_MYH:
            begin
                mul_a = MUL_W'(p_mag_reg[PMAG_W-1:MLO_W]);
                mul_b = cy_mag;
            end
            ST_MYL:
            begin
                mul_a = MUL_W'(p_mag_reg[MLO_W-1:0]);
                mul_b = cy_mag;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign creq.start = (state_reg == ST_FOLD);
    assign creq.angle = ang_folded;
    assign wreq.start = (state_reg == ST_HSTART);
    assign wreq.value = h_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_CONV;
            ST_CONV:   state_next = ST_ANG;
            ST_ANG:    state_next = ST_FOLD;
            ST_FOLD:   state_next = ST_HSUM;
            ST_HSUM:   state_next = ST_HSTART;
            ST_HSTART: state_next = ST_HWAIT;
            ST_HWAIT:  if (!cres.busy && !wres.busy) state_next = ST_MXH;
            ST_MXH:    state_next = ST_MXL;
            ST_MXL:    state_next = ST_MYH;
            ST_MYH:    state_next = ST_MYL;
            ST_MYL:    state_next = ST_ACCY;
            ST_ACCY:   state_next = ST_RND;
            ST_RND:    state_next = ST_UPD;
            ST_UPD:    state_next = ST_DONE;
            ST_DONE:   if (!m_tvalid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lin_scale_reg   <= LINEAR_SCALE_RESET;
            ang_scale_reg   <= ANGULAR_SCALE_RESET;
            x_reg           <= '0;
            y_reg           <= '0;
            heading_acc_reg <= '0;
            dist_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LINEAR_SCALE:  lin_scale_reg <= cfg_data;
                    REG_ANGULAR_SCALE: ang_scale_reg <= cfg_data;
                    default:           lin_scale_reg <= lin_scale_reg;
                endcase
            end

            if (state_reg == ST_UPD)
            begin
                x_reg           <= dx_neg ? x_reg - dxm_reg[POS_W-1:0]
                                          : x_reg + dxm_reg[POS_W-1:0];
                y_reg           <= dy_neg ? y_reg - dym_reg[POS_W-1:0]
                                          : y_reg + dym_reg[POS_W-1:0];
                heading_acc_reg <= wres.heading;
                dist_reg        <= (dist_sum[DIST_W+3:DIST_W] != '0) ? '1
                                                                    : dist_sum[DIST_W-1:0];
            end

            if (state_reg == ST_DONE && (!m_tvalid_reg || m_tready))
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                lt_reg <= s_tdata[TICK_W-1:0];
                rt_reg <= s_tdata[2*TICK_W-1:TICK_W];
                cd_reg <= s_tdata[2*TICK_W+HEAD_IN_W-1:2*TICK_W];
            end
            ST_ANG:
                ang_reg <= ang_wrapped;
            ST_FOLD:
            begin
                fold_reg  <= fold_now;
                p_mag_reg <= mul_p[PMAG_W-1:0];
                p_neg_reg <= tick_sum[TICK_W];
            end
            ST_HSUM:
                h_reg <= h_sum;
            ST_MXL:
                acc_reg <= ACC_W'(mul_p) << MLO_W;
            ST_MYH:
                acc_reg <= acc_reg + ACC_W'(mul_p);
            ST_MYL:
            begin
                dxm_reg <= acc_rnd[ACC_W-1:MUL_FRAC];
                acc_reg <= ACC_W'(mul_p) << MLO_W;
            end
            ST_ACCY:
                acc_reg <= acc_reg + ACC_W'(mul_p);
            ST_RND:
                dym_reg <= acc_rnd[ACC_W-1:MUL_FRAC];
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                    m_tdata_reg <= {{PAD_W{1'b0}}, dist_reg,
                                    heading_acc_reg[OHEAD_W-1:0], y_reg, x_reg};
            end
            default:
                acc_reg <= acc_reg;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    ap_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("word accepted but block still ready");

    ap_units_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_MXH |-> !cres.busy && !wres.busy)
        else $error("step multiply started before CORDIC or wrap finished");

    ap_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
        heading_acc_reg <= PI_Q24 && heading_acc_reg > -PI_Q24)
        else $error("heading outside (-pi, pi]");

    ap_dist_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_UPD |=> dist_reg >= $past(dist_reg))
        else $error("distance total decreased");

    ap_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result shown outside the done step");

endmodule

// ===== sv/dou_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned multiplier with a registered product.
// Depends on dou_pkg.
module dou_mul (
    input  logic                       clk,
    input  logic [dou_pkg::MUL_W-1:0]  a,
    input  logic [dou_pkg::MUL_W-1:0]  b,
    output logic [dou_pkg::PROD_W-1:0] p
);
    import dou_pkg::*;

    logic [PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

// ===== sv/dou_cordic.sv =====
`timescale 1ns / 1ps
// Iterative rotation-mode CORDIC, one micro-rotation per cycle.
// Depends on dou_pkg (arctangent table, widths, request/result types).
module dou_cordic #(
    parameter int STEPS = dou_pkg::CORDIC_STEPS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dou_pkg::cordic_req_t req,
    output dou_pkg::cordic_res_t res
);
    import dou_pkg::*;

    localparam int N_EFF = (STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : STEPS;
    localparam logic [ATAN_IDX_W-1:0] LAST = ATAN_IDX_W'(N_EFF - 1);

    logic                    busy_reg;
    logic [ATAN_IDX_W-1:0]   cnt_reg;
    logic signed [XY_W-1:0]  x_reg, y_reg, x_next, y_next;
    logic signed [ANG_W-1:0] z_reg, z_next;
    logic signed [XY_W-1:0]  xs, ys;
    logic signed [ANG_W-1:0] atan_val;

    always_comb
    begin
        xs       = x_reg >>> cnt_reg;
        ys       = y_reg >>> cnt_reg;
        atan_val = ANG_W'(signed'({1'b0, atan_q24(cnt_reg)}));
        if (!z_reg[ANG_W-1])
        begin
            x_next = x_reg - ys;
            y_next = y_reg + xs;
            z_next = z_reg - atan_val;
        end
        else
        begin
            x_next = x_reg + ys;
            y_next = y_reg - xs;
            z_next = z_reg + atan_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == LAST)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            x_reg <= CORDIC_INIT_Q30;
            y_reg <= '0;
            z_reg <= req.angle;
        end
        else if (busy_reg)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign res.busy    = busy_reg;
    assign res.cos_val = x_reg;
    assign res.sin_val = y_reg;

endmodule

// ===== sv/dou_hwrap.sv =====
`timescale 1ns / 1ps
// Heading wrap: reduces a wide signed angle modulo 2*pi into (-pi, pi]
// by restoring compare-subtract steps. Depends on dou_pkg.
module dou_hwrap (
    input  logic               clk,
    input  logic               rst_n,
    input  dou_pkg::wrap_req_t req,
    output dou_pkg::wrap_res_t res
);
    import dou_pkg::*;

    localparam logic [1:0] WR_IDLE = 2'd0;
    localparam logic [1:0] WR_RUN  = 2'd1;
    localparam logic [1:0] WR_FIN  = 2'd2;

    localparam logic [WRAP_CNT_W-1:0] WRAP_LAST = WRAP_CNT_W'(WRAP_STEPS - 1);
    localparam logic [WRAP_M_W-1:0]   DIV_INIT  =
        WRAP_M_W'(TWO_PI_Q24) << (WRAP_STEPS - 1);

    logic [1:0]              state_reg;
    logic [WRAP_CNT_W-1:0]   cnt_reg;
    logic                    neg_reg;
    logic [WRAP_M_W-1:0]     m_reg, d_reg;
    logic signed [ANG_W-1:0] heading_reg;
    logic signed [ANG_W-1:0] r_ext, v_pos, v_wrap;

    always_comb
    begin
        r_ext = signed'({1'b0, m_reg[TWO_PI_W-1:0]});
        if (neg_reg && (r_ext != '0))
            v_pos = TWO_PI_Q24 - r_ext;
        else
            v_pos = r_ext;
        if (v_pos > PI_Q24)
            v_wrap = v_pos - TWO_PI_Q24;
        else
            v_wrap = v_pos;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= WR_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                WR_IDLE:
                begin
                    if (req.start)
                    begin
                        state_reg <= WR_RUN;
                        cnt_reg   <= '0;
                    end
                end
                WR_RUN:
                begin
                    if (cnt_reg == WRAP_LAST)
                        state_reg <= WR_FIN;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                WR_FIN:
                    state_reg <= WR_IDLE;
                default:
                    state_reg <= WR_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == WR_IDLE && req.start)
        begin
            neg_reg <= req.value[H_W-1];
            m_reg   <= req.value[H_W-1] ? WRAP_M_W'(-req.value) : WRAP_M_W'(req.value);
            d_reg   <= DIV_INIT;
        end
        else if (state_reg == WR_RUN)
        begin
            if (m_reg >= d_reg)
                m_reg <= m_reg - d_reg;
            d_reg <= d_reg >> 1;
        end
        else if (state_reg == WR_FIN)
        begin
            heading_reg <= v_wrap;
        end
    end

    assign res.busy    = (state_reg != WR_IDLE);
    assign res.heading = heading_reg;

endmodule

// ===== tb/differential_odometry_update_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for differential_odometry_update: drives tick and heading
// words, predicts position, heading and distance in a scoreboard class, checks each result.
// Depends on dou_pkg and the differential_odometry_update RTL.
module differential_odometry_update_test;

    import dou_pkg::*;

    localparam int STEPS         = CORDIC_STEPS_DEF;
    localparam int SETTLE_CYCLES = 48;
    localparam int STALL_LIMIT   = 3000;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic [SCALE_W-1:0] SCALE_MAX = '1;
    localparam longint ARCTAN_Q24 [0:23] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    typedef logic signed [TICK_W-1:0]    tick_t;
    typedef logic signed [HEAD_IN_W-1:0] head_t;
    typedef logic [SCALE_W-1:0]          scale_t;

    typedef struct {
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [OHEAD_W-1:0] heading;
        logic [DIST_W-1:0]  distance;
    } odo_fix_t;

    typedef enum int {RX_OPEN, RX_QUARTER, RX_COIN, RX_LONG} rx_style_t;

    class odometry_scoreboard;
        scale_t            lin_scale;
        scale_t            ang_scale;
        logic [POS_W-1:0]  east;
        logic [POS_W-1:0]  north;
        logic [DIST_W-1:0] travelled;
        longint            heading_q24;
        odo_fix_t          outstanding[$];
        int                failures;

        function new();
            lin_scale   = LINEAR_SCALE_RESET;
            ang_scale   = ANGULAR_SCALE_RESET;
            east        = '0;
            north       = '0;
            travelled   = '0;
            heading_q24 = 0;
            failures    = 0;
        endfunction

        function void set_scale(logic [CFG_IDX_W-1:0] index, scale_t value);
            case (index)
                REG_LINEAR_SCALE:  lin_scale = value;
                REG_ANGULAR_SCALE: ang_scale = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return outstanding.size();
        endfunction

        function void rotate(longint angle, output longint cos_q30, output longint sin_q30);
            longint x;
            longint y;
            longint z;
            longint xs;
            longint ys;
            int     n;
            x = longint'(CORDIC_INIT_Q30);
            y = 0;
            z = angle;
            n = (STEPS > 24) ? 24 : STEPS;
            for (int i = 0; i < n; i++)
            begin
                xs = x >>> i;
                ys = y >>> i;
                if (z >= 0)
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ARCTAN_Q24[i];
                end
                else
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ARCTAN_Q24[i];
                end
            end
            cos_q30 = x;
            sin_q30 = y;
        endfunction

        // round(|p * c| / 2^38), half away from zero
        function logic [63:0] step_size(longint p, longint c, output bit neg);
            logic [63:0]  pm;
            logic [63:0]  cm;
            logic [127:0] prod;
            pm   = (p < 0) ? -p : p;
            cm   = (c < 0) ? -c : c;
            prod = {64'd0, pm} * {64'd0, cm};
            prod = prod + (128'd1 << 37);
            neg  = (p < 0) != (c < 0);
            return prod[101:38];
        endfunction

        function void note_word(tick_t left, tick_t right, head_t head);
            longint      lt;
            longint      rt;
            longint      cd;
            longint      angle;
            longint      cs;
            longint      sn;
            longint      p;
            longint      h;
            logic [63:0] dxm;
            logic [63:0] dym;
            logic [64:0] sum;
            bit          dxn;
            bit          dyn;
            bit          fold;
            odo_fix_t    e;
            lt = left;
            rt = right;
            cd = head;
            angle = (((cd < 0) ? -cd : cd) * longint'(DEG_TO_RAD_Q40) + 32768) >>> 16;
            if (cd < 0)
                angle = -angle;
            if (angle > longint'(PI_Q24))
                angle = angle - longint'(TWO_PI_Q24);
            else if (angle < -longint'(PI_Q24))
                angle = angle + longint'(TWO_PI_Q24);
            fold = 1'b0;
            if (angle > longint'(HALF_PI_Q24))
            begin
                angle = angle - longint'(PI_Q24);
                fold  = 1'b1;
            end
            else if (angle < -longint'(HALF_PI_Q24))
            begin
                angle = angle + longint'(PI_Q24);
                fold  = 1'b1;
            end
            rotate(angle, cs, sn);
            if (fold)
            begin
                cs = -cs;
                sn = -sn;
            end

            p   = (lt + rt) * longint'(lin_scale);
            dxm = step_size(p, cs, dxn);
            dym = step_size(p, sn, dyn);
            east  = dxn ? east - dxm[31:0] : east + dxm[31:0];
            north = dyn ? north - dym[31:0] : north + dym[31:0];
            sum = {33'd0, travelled} + {1'b0, dxm} + {1'b0, dym};
            travelled = (sum > 65'h0_FFFF_FFFF) ? '1 : sum[31:0];

            h = heading_q24 + (rt - lt) * longint'(ang_scale);
            h = h % longint'(TWO_PI_Q24);
            if (h < 0)
                h = h + longint'(TWO_PI_Q24);
            if (h > longint'(PI_Q24))
                h = h - longint'(TWO_PI_Q24);
            heading_q24 = h;

            e.pos_x    = east;
            e.pos_y    = north;
            e.heading  = OHEAD_W'(h);
            e.distance = travelled;
            outstanding.push_back(e);
        endfunction

        function void check_word(logic [OUT_TDATA_W-1:0] word);
            odo_fix_t           e;
            logic [POS_W-1:0]   got_x;
            logic [POS_W-1:0]   got_y;
            logic [OHEAD_W-1:0] got_h;
            logic [DIST_W-1:0]  got_d;
            got_x = word[31:0];
            got_y = word[63:32];
            got_h = word[90:64];
            got_d = word[122:91];
            if (outstanding.size() == 0)
            begin
                $error("result word with nothing outstanding: %h", word);
                failures++;
                return;
            end
            e = outstanding.pop_front();
            if (got_x !== e.pos_x)
            begin
                $error("pos_x: expected %0d, got %0d", $signed(e.pos_x), $signed(got_x));
                failures++;
            end
            if (got_y !== e.pos_y)
            begin
                $error("pos_y: expected %0d, got %0d", $signed(e.pos_y), $signed(got_y));
                failures++;
            end
            if (got_h !== e.heading)
            begin
                $error("own_heading: expected %0d, got %0d", $signed(e.heading),
                       $signed(got_h));
                failures++;
            end
            if (got_d !== e.distance)
            begin
                $error("distance_total: expected %0d, got %0d", e.distance, got_d);
                failures++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    // left_ticks[15:0], right_ticks[31:16], heading_centideg[47:32]
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    // pos_x[31:0], pos_y[63:32], own_heading[90:64], distance_total[122:91]
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [SCALE_W-1:0]     cfg_data;

    odometry_scoreboard sb;
    int                 burst_left;
    int                 quiet_cycles;
    rx_style_t          rx_style;
    int                 rx_window;
    int                 rx_hold;
    int                 rx_count;

    differential_odometry_update #(
        .CORDIC_STEPS(STEPS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #1 clk = ~clk;

    // receiver: drive m_tready by a stall style that is redrawn at random
    always @(negedge clk)
    begin
        logic ready;
        if (rx_window == 0)
        begin
            rx_style  = rx_style_t'($urandom_range(3));
            rx_window = $urandom_range(100, 300);
        end
        else
            rx_window--;
        rx_count++;
        case (rx_style)
            RX_OPEN:    ready = 1'b1;
            RX_QUARTER: ready = (rx_count % 4) == 0;
            RX_COIN:    ready = 1'($urandom_range(1));
            default:
            begin
                if (rx_hold > 0)
                begin
                    rx_hold--;
                    ready = 1'b0;
                end
                else
                begin
                    ready = 1'b1;
                    if ($urandom_range(7) == 0)
                        rx_hold = $urandom_range(1, 40);
                end
            end
        endcase
        m_tready <= ready;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_word(m_tdata);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    function automatic tick_t random_ticks();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return tick_t'(int'($urandom_range(200)) - 100);
        else if (roll < 85)
            return tick_t'(int'($urandom_range(8000)) - 4000);
        else
            return tick_t'($urandom);
    endfunction

    function automatic head_t random_heading();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 80)
            return head_t'(int'($urandom_range(36000)) - 18000);
        else if (roll < 92)
            return head_t'($urandom);
        case ($urandom_range(4))
            0:       return head_t'(18000);
            1:       return head_t'(-18000);
            2:       return head_t'(9000);
            3:       return head_t'(-9000);
            default: return head_t'(0);
        endcase
    endfunction

    task automatic push_word(input tick_t left, input tick_t right, input head_t head);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(4) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 6);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {head, right, left};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_word(left, right, head);
        burst_left--;
        @(negedge clk);
    endtask

    task automatic push_random(input int count);
        repeat (count)
            push_word(random_ticks(), random_ticks(), random_heading());
    endtask

    // hold off until every result is back and the block has gone quiet
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        burst_left = 0;
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index, input scale_t value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        sb.set_scale(index, value);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        burst_left   = 0;
        quiet_cycles = 0;
        rx_style     = RX_OPEN;
        rx_window    = 0;
        rx_hold      = 0;
        rx_count     = 0;
        sb = new();
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        push_word(0, 0, 0);
        push_word(32767, 32767, 0);
        push_word(-32768, -32768, 0);
        push_word(32767, -32768, 9000);
        push_word(-32768, 32767, -9000);
        push_word(100, 100, 18000);
        push_word(100, 100, -18000);
        push_word(50, 70, 4500);
        push_word(-50, 70, 13500);
        push_word(70, -50, -13500);
        push_word(1000, 1000, 17999);
        push_word(1000, 1000, -17999);
        push_word(1, 0, 1);
        push_word(0, 1, -1);
        push_word(-1, 0, 9001);
        // headings beyond half a turn: wrap by a full turn, then fold if past a quarter turn
        push_word(300, 300, 32767);
        push_word(300, 300, -32768);
        push_word(-300, 200, 20000);
        push_word(200, -300, -25000);
        push_word(500, 400, 27000);
        push_word(-1, -1, -8999);
        push_word(12345, -23456, 8999);

        push_random(200);

        settle();
        write_register(REG_LINEAR_SCALE, '0);
        write_register(REG_ANGULAR_SCALE, SCALE_MAX);
        push_random(100);

        settle();
        write_register(REG_LINEAR_SCALE, 24'd65536);
        write_register(REG_ANGULAR_SCALE, '0);
        push_random(150);

        // spare indexes must leave both scales alone
        settle();
        write_register(REG_LINEAR_SCALE, LINEAR_SCALE_RESET);
        write_register(REG_ANGULAR_SCALE, ANGULAR_SCALE_RESET);
        write_register(REG_SPARE_A, scale_t'($urandom));
        write_register(REG_SPARE_B, scale_t'($urandom));
        push_random(100);

        settle();
        write_register(REG_LINEAR_SCALE, scale_t'($urandom));
        write_register(REG_ANGULAR_SCALE, scale_t'($urandom));
        push_random(150);

        settle();
        write_register(REG_LINEAR_SCALE, SCALE_MAX);
        write_register(REG_ANGULAR_SCALE, SCALE_MAX);
        push_random(150);

        settle();
        if (sb.failures == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/dou_pkg.sv
sv/dou_mul.sv
sv/dou_cordic.sv
sv/dou_hwrap.sv
sv/differential_odometry_update.sv
tb/differential_odometry_update_test.sv
